/* design/uart_waveform_command_parser_core_macros.svh */
// assertion macros used by the checker file
// no dependencies; included by bare file name
`ifndef UART_WAVEFORM_COMMAND_PARSER_CORE_MACROS_SVH
`define UART_WAVEFORM_COMMAND_PARSER_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define UWCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define UWCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define UWCP_ASSERT_RST(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/uwcp_pkg.sv */
// types, codes and keyword table of the uart waveform command parser
// no dependencies
`default_nettype none

package uwcp_pkg;

  localparam int unsigned KW_COUNT = 5;
  localparam int unsigned KW_MAX_LEN = 8;
  localparam int unsigned KW_PROG_W = 4;

  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_VT = 8'd11;
  localparam logic [7:0] CH_FF = 8'd12;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;

  // keywords in priority order, left-aligned, first character in the top byte
  localparam logic [63:0] KW_STR [KW_COUNT] = '{
    {"sine", 32'h0},
    "triangle",
    {"square", 16'h0},
    {"ramp", 32'h0},
    {"help", 32'h0}
  };
  localparam logic [KW_PROG_W-1:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd8, 4'd6, 4'd4, 4'd4
  };
  localparam int unsigned KW_HELP = 4;

  typedef enum logic [1:0] {
    RK_WAVE     = 2'd0,
    RK_HELP     = 2'd1,
    RK_BAD_TYPE = 2'd2,
    RK_TOO_LONG = 2'd3
  } result_kind_t;

  typedef enum logic [1:0] {
    WT_SINE     = 2'd0,
    WT_TRIANGLE = 2'd1,
    WT_SQUARE   = 2'd2,
    WT_RAMP     = 2'd3
  } wave_type_t;

  typedef enum logic [2:0] {
    PH_WAIT_SPACE = 3'd0,
    PH_SKIP_WS    = 3'd1,
    PH_AFTER_SIGN = 3'd2,
    PH_DIGITS     = 3'd3,
    PH_DONE       = 3'd4
  } num_phase_t;

  // per-byte control from the line tracker to the scanners
  typedef struct packed {
    logic clear;  // line end: back to the start state
    logic scan;   // non-nul, non-line-end byte to be scanned
    logic nul;    // first nul of the line
  } scan_ctl_t;

  typedef struct packed {
    result_kind_t kind;
    wave_type_t   wave;
    logic signed [31:0] freq;
  } out_item_t;

  function automatic logic [7:0] kw_char(input int unsigned k, input logic [2:0] pos);
    kw_char = KW_STR[k][63 - 8*pos -: 8];
  endfunction

endpackage

`default_nettype wire

/* design/uwcp_if.sv */
// valid/ready channel interfaces for the byte input and the result output
// no dependencies
`default_nettype none

interface uwcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface uwcp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [1:0]         wave_type;
  logic signed [31:0] frequency;
  modport source (output valid, output result_kind, output wave_type, output frequency,
                  input ready);
  modport sink (input valid, input result_kind, input wave_type, input frequency,
                output ready);
endinterface

`default_nettype wire

/* design/uwcp_kw_bank.sv */
// five keyword matchers, one progress counter and one seen flag each
// depends on uwcp_pkg
`default_nettype none

module uwcp_kw_bank (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire uwcp_pkg::scan_ctl_t        ctl,
  input  wire logic [7:0]                 ch,
  output logic [uwcp_pkg::KW_COUNT-1:0]   found
);

  logic [uwcp_pkg::KW_COUNT-1:0] found_r, found_nxt;

  for (genvar k = 0; k < uwcp_pkg::KW_COUNT; k++) begin : g_kw
    logic [uwcp_pkg::KW_PROG_W-1:0] prog_r, prog_nxt, step;
    logic                           hit;

    // no keyword has a border, so a mismatch falls back to 0 or 1
    always_comb begin
      if (uwcp_pkg::kw_char(k, prog_r[2:0]) == ch) begin
        step = prog_r + 1'b1;
      end else if (uwcp_pkg::kw_char(k, 3'd0) == ch) begin
        step = uwcp_pkg::KW_PROG_W'(1);
      end else begin
        step = '0;
      end
      hit = (step == uwcp_pkg::KW_LEN[k]);
      prog_nxt = prog_r;
      found_nxt[k] = found_r[k];
      if (ctl.clear) begin
        prog_nxt = '0;
        found_nxt[k] = 1'b0;
      end else if (ctl.scan) begin
        prog_nxt = hit ? '0 : step;
        found_nxt[k] = found_r[k] | hit;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        prog_r <= '0;
      end else begin
        prog_r <= prog_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= '0;
    end else begin
      found_r <= found_nxt;
    end
  end

  assign found = found_r;

endmodule

`default_nettype wire

/* design/uwcp_num_parse.sv */
// atoi-style number parser behind the first space, saturating to 32 bits
// depends on uwcp_pkg
`default_nettype none

module uwcp_num_parse (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire uwcp_pkg::scan_ctl_t   ctl,
  input  wire logic [7:0]            ch,
  output logic signed [31:0]         value
);

  localparam logic [35:0] MAG_CAP = 36'h0_8000_0000;

  uwcp_pkg::num_phase_t phase_r, phase_nxt;
  logic                 neg_r, neg_nxt;
  logic [31:0]          mag_r, mag_nxt;
  logic                 is_digit, is_ws;
  logic [35:0]          mag_x10;

  assign is_digit = (ch >= uwcp_pkg::CH_ZERO) && (ch <= uwcp_pkg::CH_NINE);
  assign is_ws = (ch == uwcp_pkg::CH_SPACE) || (ch == uwcp_pkg::CH_TAB) ||
                 (ch == uwcp_pkg::CH_VT) || (ch == uwcp_pkg::CH_FF);
  // times ten as two shifts, plus the digit
  assign mag_x10 = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} +
                   {32'd0, ch[3:0] - uwcp_pkg::CH_ZERO[3:0]};

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt = neg_r;
    mag_nxt = mag_r;
    if (ctl.clear) begin
      phase_nxt = uwcp_pkg::PH_WAIT_SPACE;
      neg_nxt = 1'b0;
      mag_nxt = '0;
    end else if (ctl.nul) begin
      if (phase_r != uwcp_pkg::PH_WAIT_SPACE) begin
        phase_nxt = uwcp_pkg::PH_DONE;
      end
    end else if (ctl.scan) begin
      unique case (phase_r)
        uwcp_pkg::PH_WAIT_SPACE: begin
          if (ch == uwcp_pkg::CH_SPACE) begin
            phase_nxt = uwcp_pkg::PH_SKIP_WS;
          end
        end
        uwcp_pkg::PH_SKIP_WS, uwcp_pkg::PH_AFTER_SIGN, uwcp_pkg::PH_DIGITS: begin
          if (phase_r == uwcp_pkg::PH_SKIP_WS && is_ws) begin
            phase_nxt = phase_r;
          end else if (phase_r == uwcp_pkg::PH_SKIP_WS &&
                       (ch == uwcp_pkg::CH_PLUS || ch == uwcp_pkg::CH_MINUS)) begin
            neg_nxt = (ch == uwcp_pkg::CH_MINUS);
            phase_nxt = uwcp_pkg::PH_AFTER_SIGN;
          end else if (is_digit) begin
            mag_nxt = (mag_x10 > MAG_CAP) ? MAG_CAP[31:0] : mag_x10[31:0];
            phase_nxt = uwcp_pkg::PH_DIGITS;
          end else begin
            phase_nxt = uwcp_pkg::PH_DONE;
          end
        end
        default: phase_nxt = uwcp_pkg::PH_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= uwcp_pkg::PH_WAIT_SPACE;
      neg_r <= 1'b0;
      mag_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      neg_r <= neg_nxt;
      mag_r <= mag_nxt;
    end
  end

  // negative side reaches -2^31 exactly; positive side clips at 2^31-1
  always_comb begin
    if (neg_r) begin
      value = $signed(32'd0 - mag_r);
    end else if (mag_r[31]) begin
      value = 32'sh7FFF_FFFF;
    end else begin
      value = $signed(mag_r);
    end
  end

endmodule

`default_nettype wire

/* design/uart_waveform_command_parser_core.sv */
// top level of the uart waveform command parser: line tracking and result buffer
// depends on uwcp_pkg, uwcp_if, uwcp_kw_bank, uwcp_num_parse
//
//   channel   dir  payload                                handshake
//   in_chan   in   rx_byte[7:0]                           valid/ready
//   out_chan  out  result_kind[1:0] wave_type[1:0]        valid/ready
//                  frequency[31:0] signed
//
// one byte per cycle while ready is high; matchers, number accumulator update then
// a line end writes its result into a two-entry output buffer the same cycle,
// the main entry if free, else the skid entry; out_chan shows the main entry
// in_chan.ready drops only while both buffer entries hold untaken results
// synchronous active-low reset clears line state and empties the buffer
`default_nettype none

module uart_waveform_command_parser_core #(
  parameter int unsigned LINE_CAPACITY = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  uwcp_in_if.sink     in_chan,
  uwcp_out_if.source  out_chan
);

  localparam int unsigned FILL_W = $clog2(LINE_CAPACITY + 1);

  // line tracking
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic               nul_seen_r, nul_seen_nxt;
  logic               xfer, line_end, full;
  uwcp_pkg::scan_ctl_t ctl;

  // scanner outputs
  logic [uwcp_pkg::KW_COUNT-1:0] found;
  logic signed [31:0]            value;

  // result and output buffer
  logic                 push, pop;
  uwcp_pkg::out_item_t  res;
  logic                 main_v_r, skid_v_r;
  uwcp_pkg::out_item_t  main_r, skid_r;

  assign xfer = in_chan.valid & in_chan.ready;
  assign line_end = (in_chan.rx_byte == uwcp_pkg::CH_LF) ||
                    (in_chan.rx_byte == uwcp_pkg::CH_CR);
  assign full = (fill_r >= FILL_W'(LINE_CAPACITY));

  // bytes past a full store are dropped; bytes after a nul only count
  always_comb begin
    ctl.clear = xfer & line_end;
    ctl.scan  = xfer & ~line_end & ~full & ~nul_seen_r &
                (in_chan.rx_byte != uwcp_pkg::CH_NUL);
    ctl.nul   = xfer & ~line_end & ~full & ~nul_seen_r &
                (in_chan.rx_byte == uwcp_pkg::CH_NUL);
  end

  always_comb begin
    fill_nxt = fill_r;
    nul_seen_nxt = nul_seen_r;
    if (ctl.clear) begin
      fill_nxt = '0;
      nul_seen_nxt = 1'b0;
    end else if (xfer && !full) begin
      fill_nxt = fill_r + 1'b1;
      nul_seen_nxt = nul_seen_r | ctl.nul;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      nul_seen_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      nul_seen_r <= nul_seen_nxt;
    end
  end

  uwcp_kw_bank u_kw_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .ch    (in_chan.rx_byte),
    .found (found)
  );

  uwcp_num_parse u_num_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .ch    (in_chan.rx_byte),
    .value (value)
  );

  // result of a line end; empty lines give none
  always_comb begin
    res.kind = uwcp_pkg::RK_BAD_TYPE;
    res.wave = uwcp_pkg::WT_SINE;
    res.freq = '0;
    priority if (full) begin
      res.kind = uwcp_pkg::RK_TOO_LONG;
    end else if (found[0]) begin
      res.kind = uwcp_pkg::RK_WAVE;
      res.wave = uwcp_pkg::WT_SINE;
      res.freq = value;
    end else if (found[1]) begin
      res.kind = uwcp_pkg::RK_WAVE;
      res.wave = uwcp_pkg::WT_TRIANGLE;
      res.freq = value;
    end else if (found[2]) begin
      res.kind = uwcp_pkg::RK_WAVE;
      res.wave = uwcp_pkg::WT_SQUARE;
      res.freq = value;
    end else if (found[3]) begin
      res.kind = uwcp_pkg::RK_WAVE;
      res.wave = uwcp_pkg::WT_RAMP;
      res.freq = value;
    end else if (found[uwcp_pkg::KW_HELP]) begin
      res.kind = uwcp_pkg::RK_HELP;
    end else begin
      res.kind = uwcp_pkg::RK_BAD_TYPE;
    end
  end

  assign push = ctl.clear & (fill_r != '0);
  assign pop = main_v_r & out_chan.ready;

  // main entry drives the port; skid catches a result while main is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push && main_v_r && !pop) begin
      skid_v_r <= 1'b1;
    end else if (push) begin
      main_v_r <= 1'b1;
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push && main_v_r && !pop) begin
      skid_r <= res;
    end else if (push) begin
      main_r <= res;
    end
  end

  assign in_chan.ready = ~skid_v_r;
  assign out_chan.valid = main_v_r;
  assign out_chan.result_kind = main_r.kind;
  assign out_chan.wave_type = main_r.wave;
  assign out_chan.frequency = main_r.freq;

endmodule

`default_nettype wire

/* design/uwcp_checker.sv */
// port-level checks on the command parser, bound to the top level
// depends on uwcp_pkg and the assertion macro header
`default_nettype none
`include "uart_waveform_command_parser_core_macros.svh"

module uwcp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [7:0]  in_rx_byte,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_result_kind,
  input wire logic [1:0]  out_wave_type,
  input wire logic [31:0] out_frequency
);

  logic in_xfer, in_is_end, out_idle, non_wave;

  assign in_xfer = in_valid & in_ready;
  assign in_is_end = (in_rx_byte == uwcp_pkg::CH_LF) || (in_rx_byte == uwcp_pkg::CH_CR);
  assign out_idle = ~out_valid;
  assign non_wave = out_valid && (out_result_kind != uwcp_pkg::RK_WAVE);

  `UWCP_ASSERT_RST(a_reset_empties, clk, !rst_n, !out_valid, "result shown after reset")
  `UWCP_ASSERT_NXT(a_out_held, clk, rst_n, out_valid && !out_ready, out_valid,
    "result dropped while stalled")
  `UWCP_ASSERT_NXT(a_no_spurious, clk, rst_n, out_idle && in_xfer && !in_is_end, !out_valid,
    "result without a line end")
  `UWCP_ASSERT_IMP(a_non_wave_zero, clk, rst_n, non_wave,
    out_wave_type == 2'd0 && out_frequency == 32'd0, "non-waveform result carries data")

endmodule

bind uart_waveform_command_parser_core uwcp_checker u_uwcp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .in_rx_byte      (in_chan.rx_byte),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_result_kind (out_chan.result_kind),
  .out_wave_type   (out_chan.wave_type),
  .out_frequency   (out_chan.frequency)
);

`default_nettype wire
